@@ src/sdsr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdsr_pkg
// Shared types, constants and helpers of the SRRIP replacement block.
// ----------------------------------------------------------------------------
package sdsr_pkg;

  localparam int NUM_SETS    = 2048;
  localparam int SET_BITS    = $clog2(NUM_SETS);
  localparam int NUM_WAYS    = 16;
  localparam int WAY_BITS    = $clog2(NUM_WAYS);
  localparam int ADDR_BITS   = 48;
  localparam int STRIDE_BITS = ADDR_BITS + 1;
  localparam int INTV_W      = 17;
  localparam int ROW_W       = 2 * NUM_WAYS;
  localparam int SWP_W       = SET_BITS + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] RRPV_MAX = 2'd3;
  localparam logic [1:0] CNT_MAX  = 2'd3;

  // operation codes
  localparam logic [1:0] OP_VICTIM = 2'd0;
  localparam logic [1:0] OP_HIT    = 2'd1;
  localparam logic [1:0] OP_FILL   = 2'd2;

  // register indexes
  localparam logic [1:0] REG_THRESH = 2'd0;
  localparam logic [1:0] REG_DECAY  = 2'd1;
  localparam logic [1:0] REG_SCLR   = 2'd2;

  typedef struct packed {
    logic [1:0]           op;
    logic [SET_BITS-1:0]  set_idx;
    logic [WAY_BITS-1:0]  way;
    logic [ADDR_BITS-1:0] addr;
  } item_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0]   addr1;
    logic [STRIDE_BITS-1:0] stride1;
    logic [ADDR_BITS-1:0]   addr0;
    logic [STRIDE_BITS-1:0] stride0;
  } strm_row_t;

  typedef struct packed {
    logic [1:0]     thresh;
    logic [INTV_W-1:0] decay_intv;
    logic [INTV_W-1:0] sclr_intv;
  } cfg_t;

  function automatic logic [1:0] sat_inc(input logic [1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 2'd1;
  endfunction

  function automatic logic [1:0] sat_dec(input logic [1:0] v);
    sat_dec = (v == 2'd0) ? v : v - 2'd1;
  endfunction

  function automatic logic [ROW_W-1:0] decay_row(input logic [ROW_W-1:0] r);
    logic [ROW_W-1:0] o;
    o = r;
    for (int w = 0; w < NUM_WAYS; w++) begin
      o[2*w +: 2] = sat_dec(r[2*w +: 2]);
    end
    decay_row = o;
  endfunction

endpackage
`default_nettype wire

@@ src/sdsr_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdsr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sdsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/sdsr_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdsr_front
// Accept and classify transactions, hold them in a short queue.
// ----------------------------------------------------------------------------
module sdsr_front
  import sdsr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_mode,
  input  wire logic [10:0]          in_set_index,
  input  wire logic [3:0]           in_way,
  input  wire logic [47:0]          in_address,
  input  wire logic                 in_hit,
  input  wire logic                 busy,
  input  wire logic                 pop,
  output logic                      q_empty,
  output item_t                     q_head
);

  item_t             q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              push;
  item_t             cls;

  // classify
  always_comb begin
    if (!in_mode) begin
      cls.op = OP_VICTIM;
    end else if (in_hit) begin
      cls.op = OP_HIT;
    end else begin
      cls.op = OP_FILL;
    end
    cls.set_idx = in_set_index[SET_BITS-1:0];
    cls.way     = in_way[WAY_BITS-1:0];
    cls.addr    = in_address[ADDR_BITS-1:0];
  end

  assign in_stall = busy || (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_empty  = (cnt_r == '0);
  assign q_head   = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule
`default_nettype wire

@@ src/sdsr_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdsr_back
// Read-modify-write of set rows, stride detection, fill counting and sweeps.
// ----------------------------------------------------------------------------
module sdsr_back
  import sdsr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  cfg_t             cfg,
  input  wire logic        q_empty,
  input  item_t            q_head,
  output logic             pop,
  output logic             busy,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_victim_way,
  output logic             out_streaming,
  output logic [1:0]       out_insert_rrpv
);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_EX   = 3'd2;
  localparam logic [2:0] S_SWP  = 3'd3;

  localparam int SW = $bits(strm_row_t);

  logic [2:0]          state_r, state_nxt;
  item_t               cur_r, cur_nxt;
  logic [SWP_W-1:0]    swc_r, swc_nxt;
  logic                wv_r, wv_nxt;
  logic [SET_BITS-1:0] wa_r, wa_nxt;
  logic                dec_r, dec_nxt, clr_r, clr_nxt;
  logic [INTV_W-1:0]   fd_r, fd_nxt, fs_r, fs_nxt;
  logic                ov_r, ov_nxt;
  logic [3:0]          ovw_r, ovw_nxt;
  logic                ost_r, ost_nxt;
  logic [1:0]          oins_r, oins_nxt;

  logic [SET_BITS-1:0] raddr;
  logic [ROW_W-1:0]    rrpv_rd, dead_rd, rrpv_wd, dead_wd;
  strm_row_t           strm_rd, strm_wd;
  logic [3:0]          hits_rd, hits_wd;
  logic                rrpv_we, dead_we, strm_we, hits_we;
  logic [SET_BITS-1:0] rrpv_wa, dead_wa, strm_wa, hits_wa;

  logic                can_write, res_load;

  // execute datapath
  logic [1:0]             top;
  logic [ROW_W-1:0]       aged;
  logic [WAY_BITS-1:0]    vict;
  logic                   vfound;
  logic [STRIDE_BITS-1:0] d0, d1;
  logic                   m0, m1, strm;
  strm_row_t              srow;
  logic [3:0]             hrow;
  logic [1:0]             h0n, h1n, dv, ins;
  logic [ROW_W-1:0]       rrow, drow;
  logic [INTV_W:0]        fd_inc, fs_inc;
  logic                   fd_fire, fs_fire;

  sdsr_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_rrpv (
    .clk, .we(rrpv_we), .waddr(rrpv_wa), .wdata(rrpv_wd), .raddr, .rdata(rrpv_rd));
  sdsr_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_dead (
    .clk, .we(dead_we), .waddr(dead_wa), .wdata(dead_wd), .raddr, .rdata(dead_rd));
  sdsr_ram #(.WIDTH(SW), .DEPTH(NUM_SETS)) u_strm (
    .clk, .we(strm_we), .waddr(strm_wa), .wdata(strm_wd), .raddr, .rdata(strm_rd));
  sdsr_ram #(.WIDTH(4), .DEPTH(NUM_SETS)) u_hits (
    .clk, .we(hits_we), .waddr(hits_wa), .wdata(hits_wd), .raddr, .rdata(hits_rd));

  // victim search: age by 3 - max, first way at the old max
  always_comb begin
    top = 2'd0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (rrpv_rd[2*w +: 2] > top) top = rrpv_rd[2*w +: 2];
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged[2*w +: 2] = rrpv_rd[2*w +: 2] + (RRPV_MAX - top);
    end
    vict   = '0;
    vfound = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!vfound && rrpv_rd[2*w +: 2] == top) begin
        vict   = WAY_BITS'(w);
        vfound = 1'b1;
      end
    end
  end

  // stride detector
  always_comb begin
    d0   = {1'b0, cur_r.addr} - {1'b0, strm_rd.addr0};
    d1   = {1'b0, cur_r.addr} - {1'b0, strm_rd.addr1};
    m0   = (strm_rd.stride0 != '0) && (d0 == strm_rd.stride0);
    m1   = (strm_rd.stride1 != '0) && (d1 == strm_rd.stride1);
    h0n  = sat_inc(hits_rd[1:0]);
    h1n  = sat_inc(hits_rd[3:2]);
    srow = strm_rd;
    hrow = hits_rd;
    strm = 1'b0;
    priority if (m0) begin
      hrow[1:0]  = h0n;
      srow.addr0 = cur_r.addr;
      strm       = (h0n >= cfg.thresh);
    end else if (m1) begin
      hrow[3:2]  = h1n;
      srow.addr1 = cur_r.addr;
      strm       = (h1n >= cfg.thresh);
    end else if (strm_rd.addr0 <= strm_rd.addr1) begin
      srow.stride0 = d0;
      srow.addr0   = cur_r.addr;
      hrow[1:0]    = 2'd1;
    end else begin
      srow.stride1 = d1;
      srow.addr1   = cur_r.addr;
      hrow[3:2]    = 2'd1;
    end
  end

  // per-way update
  always_comb begin
    dv   = dead_rd[2*cur_r.way +: 2];
    rrow = rrpv_rd;
    drow = dead_rd;
    priority if (strm) ins = RRPV_MAX;
    else if (dv == 2'd0) ins = 2'd0;
    else if (dv == 2'd1) ins = 2'd1;
    else ins = RRPV_MAX;
    if (cur_r.op == OP_HIT) begin
      rrow[2*cur_r.way +: 2] = 2'd0;
      drow[2*cur_r.way +: 2] = sat_dec(dv);
    end else begin
      rrow[2*cur_r.way +: 2] = ins;
      drow[2*cur_r.way +: 2] = sat_inc(dv);
    end
    fd_inc  = {1'b0, fd_r} + 1'b1;
    fs_inc  = {1'b0, fs_r} + 1'b1;
    fd_fire = (fd_inc >= {1'b0, cfg.decay_intv});
    fs_fire = (fs_inc >= {1'b0, cfg.sclr_intv});
  end

  assign can_write = !ov_r || !out_stall;
  assign res_load  = (state_r == S_EX) && can_write;

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    swc_nxt   = swc_r;
    wv_nxt    = 1'b0;
    wa_nxt    = wa_r;
    dec_nxt   = dec_r;
    clr_nxt   = clr_r;
    fd_nxt    = fd_r;
    fs_nxt    = fs_r;
    ov_nxt    = ov_r && out_stall;
    ovw_nxt   = ovw_r;
    ost_nxt   = ost_r;
    oins_nxt  = oins_r;
    pop       = 1'b0;
    raddr     = cur_r.set_idx;
    rrpv_we   = 1'b0; rrpv_wa = cur_r.set_idx; rrpv_wd = rrow;
    dead_we   = 1'b0; dead_wa = cur_r.set_idx; dead_wd = drow;
    strm_we   = 1'b0; strm_wa = cur_r.set_idx; strm_wd = srow;
    hits_we   = 1'b0; hits_wa = cur_r.set_idx; hits_wd = hrow;
    unique case (state_r)
      S_INIT: begin
        // write reset values row by row
        rrpv_we = 1'b1; rrpv_wa = swc_r[SET_BITS-1:0]; rrpv_wd = '1;
        dead_we = 1'b1; dead_wa = swc_r[SET_BITS-1:0]; dead_wd = '0;
        strm_we = 1'b1; strm_wa = swc_r[SET_BITS-1:0]; strm_wd = '0;
        hits_we = 1'b1; hits_wa = swc_r[SET_BITS-1:0]; hits_wd = '0;
        swc_nxt = swc_r + 1'b1;
        if (swc_r == SWP_W'(NUM_SETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        raddr = q_head.set_idx;
        if (!q_empty) begin
          pop       = 1'b1;
          cur_nxt   = q_head;
          state_nxt = S_EX;
        end
      end
      S_EX: begin
        if (can_write) begin
          ov_nxt    = 1'b1;
          ovw_nxt   = '0;
          ost_nxt   = 1'b0;
          oins_nxt  = '0;
          state_nxt = S_IDLE;
          if (cur_r.op == OP_VICTIM) begin
            ovw_nxt = 4'(vict);
            rrpv_we = 1'b1;
            rrpv_wd = aged;
          end else begin
            ost_nxt = strm;
            rrpv_we = 1'b1;
            dead_we = 1'b1;
            strm_we = 1'b1;
            hits_we = 1'b1;
            if (cur_r.op == OP_FILL) begin
              oins_nxt = ins;
              fd_nxt   = fd_fire ? '0 : fd_inc[INTV_W-1:0];
              fs_nxt   = fs_fire ? '0 : fs_inc[INTV_W-1:0];
              if (fd_fire || fs_fire) begin
                dec_nxt   = fd_fire;
                clr_nxt   = fs_fire;
                swc_nxt   = '0;
                state_nxt = S_SWP;
              end
            end
          end
        end
      end
      S_SWP: begin
        // read row n, write it back decayed in the next cycle
        raddr   = swc_r[SET_BITS-1:0];
        dead_we = wv_r;
        dead_wa = wa_r;
        dead_wd = decay_row(dead_rd);
        if (swc_r != SWP_W'(NUM_SETS)) begin
          hits_we = clr_r;
          hits_wa = swc_r[SET_BITS-1:0];
          hits_wd = '0;
          wv_nxt  = dec_r;
          wa_nxt  = swc_r[SET_BITS-1:0];
          swc_nxt = swc_r + 1'b1;
        end else if (!wv_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      swc_r   <= '0;
      wv_r    <= 1'b0;
      dec_r   <= 1'b0;
      clr_r   <= 1'b0;
      fd_r    <= '0;
      fs_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      swc_r   <= swc_nxt;
      wv_r    <= wv_nxt;
      dec_r   <= dec_nxt;
      clr_r   <= clr_nxt;
      fd_r    <= fd_nxt;
      fs_r    <= fs_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    wa_r   <= wa_nxt;
    ovw_r  <= ovw_nxt;
    ost_r  <= ost_nxt;
    oins_r <= oins_nxt;
  end

  assign busy            = (state_r == S_INIT);
  assign out_valid       = ov_r;
  assign out_victim_way  = ovw_r;
  assign out_streaming   = ost_r;
  assign out_insert_rrpv = oins_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> state_r == S_IDLE)
    else $error("pop outside idle");
  a_ex_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EX && !can_write) |=> state_r == S_EX)
    else $error("execute left while result blocked");
  a_load_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> ($past(pop) || $past(state_r == S_EX)))
    else $error("result without a popped transaction");
  a_sweep_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWP && dead_we) |-> dec_r)
    else $error("dead row written in clear-only sweep");

endmodule
`default_nettype wire

@@ src/srrip_deadblock_stream_replacement_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srrip_deadblock_stream_replacement_top
// SRRIP replacement with dead-block prediction and per-set stride detection.
// ----------------------------------------------------------------------------
// In the back end the set's RRPV, dead-counter and detector rows are first
// read from the set memories, then computed and written back. A four-entry
// queue in front keeps taking transactions meanwhile, and a result register
// lets the next one be fetched and read while a result waits. A fill that
// reaches a decay or stream-clear interval starts a sweep over the set
// memories before the next transaction is executed; a decay sweep ends only
// once its last row is written back, since each decayed row is written in
// the cycle after it is read. After reset a clearing pass writes the reset
// values into all NUM_SETS (2048) rows; in_stall is held high throughout
// it.
// Registers: 0x0 stream threshold, 0x4 decay interval, 0x8 stream-clear
// interval; write only while idle.
// ----------------------------------------------------------------------------
module srrip_deadblock_stream_replacement_top
  import sdsr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_mode,
  input  wire logic [10:0] in_set_index,
  input  wire logic [3:0]  in_way,
  input  wire logic [47:0] in_address,
  input  wire logic        in_hit,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_victim_way,
  output logic             out_streaming,
  output logic [1:0]       out_insert_rrpv,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t  cfg_r, cfg_nxt;
  logic  q_empty, pop, busy, wr_en;
  item_t q_head;

  // configuration registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_THRESH: cfg_nxt.thresh     = pwdata[1:0];
        REG_DECAY:  cfg_nxt.decay_intv = pwdata[INTV_W-1:0];
        REG_SCLR:   cfg_nxt.sclr_intv  = pwdata[INTV_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_THRESH: prdata = {30'd0, cfg_r.thresh};
      REG_DECAY:  prdata = {{(32-INTV_W){1'b0}}, cfg_r.decay_intv};
      REG_SCLR:   prdata = {{(32-INTV_W){1'b0}}, cfg_r.sclr_intv};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thresh     <= 2'd3;
      cfg_r.decay_intv <= INTV_W'(8192);
      cfg_r.sclr_intv  <= INTV_W'(4096);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // accept and queue
  sdsr_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_mode, .in_set_index, .in_way,
    .in_address, .in_hit, .busy, .pop, .q_empty, .q_head);

  // execute, sweep and hold the result
  sdsr_back u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_empty, .q_head, .pop, .busy,
    .out_valid, .out_stall, .out_victim_way, .out_streaming, .out_insert_rrpv);

endmodule
`default_nettype wire

@@ verif/srrip_deadblock_stream_replacement_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrip_deadblock_stream_replacement_checker
// Watches the access, result and register channels, keeps a private copy of
// the replacement state and compares each result with its prediction.
// ----------------------------------------------------------------------------
module srrip_deadblock_stream_replacement_checker
  import sdsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_mode,
  input  logic [10:0] in_set_index,
  input  logic [3:0]  in_way,
  input  logic [47:0] in_address,
  input  logic        in_hit,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  out_victim_way,
  input  logic        out_streaming,
  input  logic [1:0]  out_insert_rrpv,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [3:0] victim;
    logic       strm;
    logic [1:0] ins;
  } verdict_t;

  logic [1:0]             rrpv_mem [NUM_SETS*NUM_WAYS];
  logic [1:0]             dead_mem [NUM_SETS*NUM_WAYS];
  logic [ADDR_BITS-1:0]   prev_addr [NUM_SETS*2];
  logic [STRIDE_BITS-1:0] last_stride [NUM_SETS*2];
  logic [1:0]             run_count [NUM_SETS*2];
  logic [1:0]             thresh;
  int                     decay_intv, sclr_intv, fills_decay, fills_sclr;
  verdict_t               expected_results [$];

  function automatic logic [3:0] pick_victim_way(input int base);
    logic [1:0] top;
    top = 0;
    for (int w = 0; w < NUM_WAYS; w++) if (rrpv_mem[base+w] > top) top = rrpv_mem[base+w];
    if (top < RRPV_MAX)
      for (int w = 0; w < NUM_WAYS; w++) rrpv_mem[base+w] += RRPV_MAX - top;
    for (int w = 0; w < NUM_WAYS; w++) if (rrpv_mem[base+w] == RRPV_MAX) return 4'(w);
    return 4'd0;
  endfunction

  function automatic logic track_stride(input int set, input logic [ADDR_BITS-1:0] a);
    int                     b, e;
    logic [STRIDE_BITS-1:0] d;
    b = set * 2;
    for (int i = 0; i < 2; i++) begin
      e = b + i;
      d = {1'b0, a} - {1'b0, prev_addr[e]};
      if (last_stride[e] != 0 && d == last_stride[e]) begin
        if (run_count[e] < CNT_MAX) run_count[e]++;
        prev_addr[e] = a;
        return run_count[e] >= thresh;
      end
    end
    e = (prev_addr[b] <= prev_addr[b+1]) ? b : b + 1;
    last_stride[e] = {1'b0, a} - {1'b0, prev_addr[e]};
    prev_addr[e]   = a;
    run_count[e]   = 2'd1;
    return 1'b0;
  endfunction

  function automatic verdict_t apply_access(input logic m, input int set, input int way,
                                            input logic [ADDR_BITS-1:0] a, input logic h);
    verdict_t v;
    int       idx;
    v   = '0;
    idx = set * NUM_WAYS + way;
    if (!m) begin
      v.victim = pick_victim_way(set * NUM_WAYS);
      return v;
    end
    v.strm = track_stride(set, a);
    if (h) begin
      rrpv_mem[idx] = 0;
      if (dead_mem[idx] > 0) dead_mem[idx]--;
      return v;
    end
    if (v.strm) v.ins = RRPV_MAX;
    else if (dead_mem[idx] == 0) v.ins = 0;
    else if (dead_mem[idx] == 1) v.ins = 1;
    else v.ins = RRPV_MAX;
    rrpv_mem[idx] = v.ins;
    if (dead_mem[idx] < CNT_MAX) dead_mem[idx]++;
    fills_decay++;
    if (fills_decay >= decay_intv) begin
      fills_decay = 0;
      foreach (dead_mem[i]) if (dead_mem[i] > 0) dead_mem[i]--;
    end
    fills_sclr++;
    if (fills_sclr >= sclr_intv) begin
      fills_sclr = 0;
      foreach (run_count[i]) run_count[i] = 0;
    end
    return v;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      foreach (rrpv_mem[i]) begin
        rrpv_mem[i] = RRPV_MAX;
        dead_mem[i] = 0;
      end
      foreach (prev_addr[i]) begin
        prev_addr[i]   = 0;
        last_stride[i] = 0;
        run_count[i]   = 0;
      end
      thresh      = 3;
      decay_intv  = 8192;
      sclr_intv   = 4096;
      fills_decay = 0;
      fills_sclr  = 0;
      fail_count  = 0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_THRESH: thresh     = pwdata[1:0];
          REG_DECAY:  decay_intv = pwdata[INTV_W-1:0];
          REG_SCLR:   sclr_intv  = pwdata[INTV_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_results.push_back(apply_access(in_mode, in_set_index, in_way,
                                                in_address, in_hit));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result victim=%0d strm=%0b ins=%0d", $time,
                   out_victim_way, out_streaming, out_insert_rrpv);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (want.victim !== out_victim_way || want.strm !== out_streaming ||
              want.ins !== out_insert_rrpv) begin
            $display("%0t: mismatch expected victim=%0d strm=%0b ins=%0d, actual %0d %0b %0d",
                     $time, want.victim, want.strm, want.ins, out_victim_way,
                     out_streaming, out_insert_rrpv);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

@@ verif/srrip_deadblock_stream_replacement_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrip_deadblock_stream_replacement_top_tb
// Drives cache accesses and register writes into the replacement block and
// gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module srrip_deadblock_stream_replacement_top_tb;
  import sdsr_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic        in_mode = 0;
  logic [10:0] in_set_index = 0;
  logic [3:0]  in_way = 0;
  logic [47:0] in_address = 0;
  logic        in_hit = 0;
  logic        out_valid;
  logic        out_stall = 1;
  logic [3:0]  out_victim_way;
  logic        out_streaming;
  logic [1:0]  out_insert_rrpv;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending;
  int          sent = 0;
  int          idle_cycles = 0;
  bit          steady = 0;   // no random idling on either side while set

  always #5 clk = ~clk;

  srrip_deadblock_stream_replacement_top u_top (.*);

  srrip_deadblock_stream_replacement_checker u_chk (.*);

  // Watchdog: count cycles with no transaction on either channel. Sweeps,
  // the clearing pass and the long receiver hold-off all fit within its limit.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 50000) begin
      $display("FAIL srrip_deadblock_stream_replacement_top");
      $finish;
    end
  end

  // Receiver: random stall per result, with one long hold-off so that the
  // input queue fills up and the block stalls its input.
  initial begin
    int results, w;
    results = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      w = steady ? 0 : $urandom_range(0, 11);
      if (results == 400) w = 300;
      if (w > 0) begin
        out_stall <= 1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results++;
    end
  end

  // Send one access; hold valid high across back-to-back transactions.
  task automatic send(input logic m, input logic [10:0] s, input logic [3:0] w,
                      input logic [47:0] a, input logic h);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1;
    in_mode      <= m;
    in_set_index <= s;
    in_way       <= w;
    in_address   <= a;
    in_hit       <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (sent % 64 == 0) steady = ($urandom_range(0, 3) == 0);
  endtask

  // Drop valid, drain every outstanding result, then allow a full sweep.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] r, input logic [31:0] v);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    @(posedge clk);
  endtask

  function automatic logic [47:0] rand_addr();
    return 48'({$urandom, $urandom});
  endfunction

  // Well-formed burst: a constant-stride run on one set, usually from a small pool, with
  // hits, fills and victim requests mixed in; otherwise plain noise.
  task automatic random_burst();
    logic [10:0] s;
    logic [47:0] a;
    logic [47:0] stride;
    int          len;
    if ($urandom_range(0, 9) < 7) begin
      s      = ($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'($urandom_range(0, 5) * 341);
      a      = ($urandom_range(0, 4) == 0) ? rand_addr() : 48'($urandom_range(0, 4095) * 64);
      stride = ($urandom_range(0, 5) == 0) ? rand_addr() : 48'($urandom_range(1, 8) * 64);
      if ($urandom_range(0, 1)) stride = -stride;
      len = $urandom_range(3, 9);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 4) == 0) send(0, s, 4'($urandom), rand_addr(), 1'($urandom));
        send(1, s, 4'($urandom), a, $urandom_range(0, 2) == 0);
        a += stride;
      end
    end else begin
      send(1'($urandom), 11'($urandom), 4'($urandom), rand_addr(), 1'($urandom));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: reset settings, set and way extremes, dead counter walk,
    // hits, set ageing, a stride run and address wrap-around.
    send(0, 0, 0, 0, 0);
    send(1, 0, 0, 48'h0, 0);
    send(1, 0, 0, 48'h0, 0);
    send(1, 0, 0, 48'h0, 0);
    send(1, 0, 0, 48'h0, 0);
    send(1, 0, 0, 48'h0, 1);
    send(1, 11'd2047, 4'd15, 48'hFFFF_FFFF_FFFF, 0);
    send(1, 11'd2047, 4'd15, 48'hFFFF_FFFF_FFFF, 1);
    send(0, 11'd2047, 0, 0, 0);
    for (int w = 0; w < 16; w++) send(1, 11'd5, 4'(w), 48'h1000 + w, 1);
    send(0, 11'd5, 0, 0, 0);
    for (int i = 0; i < 6; i++) send(1, 11'd9, 4'd3, 48'h100 + 64 * i, 0);
    send(1, 11'd9, 4'd3, 48'h0000_0000_0010, 0);
    send(1, 11'd9, 4'd3, 48'hFFFF_FFFF_FFF0, 0);
    drain();

    // Intervals of 1 and threshold 1: sweep on every fill.
    write_reg(REG_THRESH, 32'hFFFF_FFFD);
    write_reg(REG_DECAY, 32'hFFFE_0001);
    write_reg(REG_SCLR, 32'd1);
    repeat (6) random_burst();
    drain();

    // Intervals of 65536, middle threshold.
    write_reg(REG_THRESH, 32'd2);
    write_reg(REG_DECAY, 32'd65536);
    write_reg(REG_SCLR, 32'd65536);
    while (sent < 400) random_burst();
    drain();
    while (sent < 700) random_burst();
    drain();

    // Zero threshold and short intervals below the counters reached so far.
    write_reg(REG_THRESH, 32'd0);
    write_reg(REG_DECAY, 32'd37);
    write_reg(REG_SCLR, 32'd23);
    while (sent < 1300) random_burst();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("PASS srrip_deadblock_stream_replacement_top");
    else $display("FAIL srrip_deadblock_stream_replacement_top");
    $finish;
  end

endmodule
